// ===== rtl/tea_pkg.sv =====
package tea_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int SQ_W     = 32;
  localparam int TOWER_W  = 16;
  localparam int ENERGY_W = 40;
  localparam int FRAC_W   = 16;

  // Square root: radicand is (mom_sq + mass_sq) << FRAC_W, root has 25 bits
  localparam int RAD_W  = SQ_W + 1;
  localparam int ROOT_W = 25;
  localparam int X_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;

  // Stream packing
  localparam int IN_DATA_W  = 2 * SQ_W + TOWER_W;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = ENERGY_W;
  localparam int OUT_USER_W = 2;

  // Store entry: valid flag above the energy
  localparam int ENTRY_W = ENERGY_W + 1;

  localparam int TOWER_COUNT_DEF = 4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

endpackage

// ===== rtl/tea_ram.sv =====
module tea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tea_sqrt.sv =====
module tea_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tea_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [tea_pkg::ROOT_W-1:0] root
);

  import tea_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [X_W-1:0]    x_r, x_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+2:0]  trial;

  // One root bit per cycle: bring down two radicand bits, try subtracting 4q+1
  assign rem_sh = {rem_r, x_r[X_W-1 -: 2]};
  assign trial  = {1'b0, rem_sh} - {2'b00, q_r, 2'b01};

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = X_W'({radicand, FRAC_W'(0)});
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[X_W-3:0], 2'b00};
      if (!trial[REM_W+2]) begin
        rem_nxt = trial[REM_W-1:0];
        q_nxt   = {q_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[REM_W-1:0];
        q_nxt   = {q_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign root = q_r;

endmodule

// ===== rtl/tower_energy_accumulator_core.sv =====
// Per-tower track energy accumulator. Each add transfer carries squared
// momentum and squared mass (16 fraction bits); the block takes
// E = floor(sqrt((mom_sq + mass_sq) * 2^16)) and adds it into a saturating
// 40-bit sum for the addressed tower. A query returns the sum, a hit flag and
// an out-of-range flag; a clear empties every tower. One item is in work at a
// time. An add runs from transfer to the next ready as follows: the bit-serial
// square root unit produces one root bit per cycle, then the block reads and
// then writes the tower store. A query reads the store, then loads the output
// register once it is free. A clear, and the pass that follows reset, sweep
// the tower store one entry per cycle with in_tready low. Out-of-range adds
// and kind code 3 are dropped without leaving the idle state.
module tower_energy_accumulator_core #(
  parameter int TOWER_COUNT = tea_pkg::TOWER_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // mom_sq [31:0], mass_sq [63:32], tower [79:64]
  input  logic [tea_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind [1:0]
  input  logic [tea_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // energy_sum [39:0]
  output logic [tea_pkg::OUT_DATA_W-1:0] out_tdata,
  // tower_hit [0], bad_tower [1]
  output logic [tea_pkg::OUT_USER_W-1:0] out_tuser
);

  import tea_pkg::*;

  localparam int AW = (TOWER_COUNT > 1) ? $clog2(TOWER_COUNT) : 1;
  localparam logic [TOWER_W:0] TOWER_LIMIT = (TOWER_W + 1)'(TOWER_COUNT);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SQRT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_Q_RD,
    ST_Q_RES
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [TOWER_W-1:0]  tower_r, tower_nxt;
  logic                bad_r, bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ENERGY_W-1:0] out_energy_r, out_energy_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic [SQ_W-1:0]     in_mom_sq;
  logic [SQ_W-1:0]     in_mass_sq;
  logic [TOWER_W-1:0]  in_tower;
  kind_t               in_kind;
  logic                in_xfer;
  logic                in_range;

  logic                sqrt_start;
  logic [RAD_W-1:0]    sqrt_rad;
  logic                sqrt_done;
  logic [ROOT_W-1:0]   sqrt_root;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                entry_valid;
  logic [ENERGY_W-1:0] entry_energy;
  logic [ENERGY_W:0]   acc_sum;
  logic [ENERGY_W-1:0] acc_new;
  logic                out_free;

  assign in_mom_sq  = in_tdata[SQ_W-1:0];
  assign in_mass_sq = in_tdata[2*SQ_W-1:SQ_W];
  assign in_tower   = in_tdata[IN_DATA_W-1:2*SQ_W];
  assign in_kind    = kind_t'(in_tuser);

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_range  = {1'b0, in_tower} < TOWER_LIMIT;

  assign sqrt_start = in_xfer && (in_kind == KIND_ADD) && in_range;
  assign sqrt_rad   = RAD_W'(in_mom_sq) + RAD_W'(in_mass_sq);

  tea_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Saturating accumulate; an empty tower loads the new energy
  assign entry_valid  = ram_rdata[ENERGY_W];
  assign entry_energy = ram_rdata[ENERGY_W-1:0];
  assign acc_sum      = {1'b0, entry_energy} + (ENERGY_W + 1)'(sqrt_root);

  always_comb begin
    if (!entry_valid) begin
      acc_new = ENERGY_W'(sqrt_root);
    end else if (acc_sum[ENERGY_W]) begin
      acc_new = '1;
    end else begin
      acc_new = acc_sum[ENERGY_W-1:0];
    end
  end

  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_ACC_WR);
  assign ram_waddr = (state_r == ST_CLR) ? clr_cnt_r : tower_r[AW-1:0];
  assign ram_wdata = (state_r == ST_CLR) ? '0 : {1'b1, acc_new};
  assign ram_re    = (state_r == ST_ACC_RD) || (state_r == ST_Q_RD);

  tea_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOWER_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tower_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    tower_nxt      = tower_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_energy_nxt = out_energy_r;
    out_hit_nxt    = out_hit_r;
    out_bad_nxt    = out_bad_r;
    case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(TOWER_COUNT - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          tower_nxt = in_tower;
          bad_nxt   = !in_range;
          case (in_kind)
            KIND_CLEAR: state_nxt = ST_CLR;
            KIND_ADD: begin
              if (in_range) begin
                state_nxt = ST_SQRT;
              end
            end
            KIND_QUERY: state_nxt = ST_Q_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_ACC_RD;
        end
      end
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: state_nxt = ST_IDLE;
      ST_Q_RD:   state_nxt = ST_Q_RES;
      ST_Q_RES: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = !bad_r && entry_valid;
          out_bad_nxt    = bad_r;
          out_energy_nxt = (!bad_r && entry_valid) ? entry_energy : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tower_r      <= tower_nxt;
    bad_r        <= bad_nxt;
    out_energy_r <= out_energy_nxt;
    out_hit_r    <= out_hit_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_energy_r;
  assign out_tuser  = {out_bad_r, out_hit_r};

endmodule
